FILE: rtl/mwc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mwc_pkg
// Shared constants, codes and types of the minimum window cover unit.
// ---------------------------------------------------------------------------
package mwc_pkg;

  localparam int MAX_LEN_DEF  = 4096;
  localparam int ALPHABET_DEF = 128;

  localparam int KIND_W   = 2;
  localparam int SYM_W    = 7;
  localparam int START_W  = 12;
  localparam int LENGTH_W = 13;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [KIND_W-1:0] KIND_PATTERN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

  typedef enum logic [1:0] {
    OP_PATTERN,
    OP_TEXT,
    OP_END
  } mwc_op_t;

  typedef struct packed {
    mwc_op_t          op;
    logic [SYM_W-1:0] sym;
  } mwc_cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PAT,
    BK_TXT,
    BK_CHECK,
    BK_FETCH,
    BK_GIVE
  } mwc_state_t;

endpackage

FILE: rtl/mwc_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mwc_front
// Accepts input items, decodes the kind, folds the symbol into the alphabet
// and pushes a command into the queue. Unused kinds are dropped here.
// ---------------------------------------------------------------------------
module mwc_front #(
  parameter int ALPHABET = mwc_pkg::ALPHABET_DEF
) (
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [mwc_pkg::KIND_W-1:0]  kind,
  input  logic [mwc_pkg::SYM_W-1:0]   symbol,
  input  logic                        q_full,
  output logic                        push,
  output mwc_pkg::mwc_cmd_t           cmd
);
  import mwc_pkg::*;

  localparam int SYM_CODES = 1 << SYM_W;

  logic [SYM_W-1:0] fold_tab [SYM_CODES];

  // symbol modulo alphabet, worked out at elaboration
  for (genvar g = 0; g < SYM_CODES; g++) begin : g_fold
    assign fold_tab[g] = SYM_W'(g % ALPHABET);
  end

  assign item_stall = q_full;

  always_comb begin
    cmd.sym = fold_tab[symbol];
    cmd.op  = OP_PATTERN;
    push    = 1'b0;
    case (kind)
      KIND_PATTERN: begin
        cmd.op = OP_PATTERN;
        push   = item_valid && !q_full;
      end
      KIND_TEXT: begin
        cmd.op = OP_TEXT;
        push   = item_valid && !q_full;
      end
      KIND_END: begin
        cmd.op = OP_END;
        push   = item_valid && !q_full;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/mwc_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mwc_queue
// Short command queue between the front and the back.
// ---------------------------------------------------------------------------
module mwc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mwc_pkg::mwc_cmd_t push_cmd,
  output logic              full,
  output logic              q_valid,
  output mwc_pkg::mwc_cmd_t q_cmd,
  input  logic              q_pop
);
  import mwc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mwc_cmd_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full    = (fill == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: rtl/mwc_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mwc_back
// Sequencer that carries out queued commands: keeps the demand count table
// and the text buffer, slides the left edge and holds the result register.
// ---------------------------------------------------------------------------
module mwc_back #(
  parameter int MAX_LEN  = mwc_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = mwc_pkg::ALPHABET_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  mwc_pkg::mwc_cmd_t             q_cmd,
  output logic                          q_pop,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          found,
  output logic [mwc_pkg::START_W-1:0]   window_start,
  output logic [mwc_pkg::LENGTH_W-1:0]  window_length,
  output logic                          overflow
);
  import mwc_pkg::*;

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int CNT_W  = LEN_W + 1;
  localparam int TPOS_W = $clog2(MAX_LEN);
  localparam int ADDR_W = $clog2(ALPHABET);
  localparam logic [LEN_W-1:0] LIMIT = LEN_W'(MAX_LEN);

  mwc_state_t state, state_next;

  logic [LEN_W-1:0]  left_edge, left_edge_next;
  logic [LEN_W-1:0]  text_count, text_count_next;
  logic [LEN_W-1:0]  missing_total, missing_total_next;
  logic [LEN_W-1:0]  pattern_total, pattern_total_next;
  logic [LEN_W-1:0]  best_start, best_start_next;
  logic [LEN_W-1:0]  best_length, best_length_next;
  logic              best_found, best_found_next;
  logic              overflow_seen, overflow_seen_next;
  logic [ADDR_W-1:0] cur_addr, cur_addr_next;

  // demand count table; entries not yet written since the last job read as zero
  logic [CNT_W-1:0]    cnt_mem [ALPHABET];
  logic [ALPHABET-1:0] cnt_valid;
  logic [CNT_W-1:0]    cnt_rdata;
  logic                cnt_rvalid;
  logic                cnt_rd;
  logic [ADDR_W-1:0]   cnt_raddr;
  logic                cnt_we;
  logic [CNT_W-1:0]    cnt_wdata;
  logic                cnt_clear;

  logic [SYM_W-1:0]  text_mem [MAX_LEN];
  logic [SYM_W-1:0]  text_rdata;
  logic              text_we;
  logic              text_rd;

  logic              res_load;

  logic [CNT_W-1:0]  cnt_cur;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  cnt_dec;
  logic              inc_pos;
  logic              dec_nonneg;
  logic [LEN_W-1:0]  win_len;
  logic [ADDR_W-1:0] q_addr;
  logic              covered;

  assign cnt_cur    = cnt_rvalid ? cnt_rdata : '0;
  assign cnt_inc    = cnt_cur + CNT_W'(1);
  assign cnt_dec    = cnt_cur - CNT_W'(1);
  assign inc_pos    = !cnt_inc[CNT_W-1] && (cnt_inc != '0);
  assign dec_nonneg = !cnt_dec[CNT_W-1];
  assign win_len    = text_count - left_edge;
  assign q_addr     = ADDR_W'(q_cmd.sym);
  assign covered    = (pattern_total != '0) && (missing_total == '0) &&
                      (left_edge < text_count);

  always_comb begin
    state_next         = state;
    left_edge_next     = left_edge;
    text_count_next    = text_count;
    missing_total_next = missing_total;
    pattern_total_next = pattern_total;
    best_start_next    = best_start;
    best_length_next   = best_length;
    best_found_next    = best_found;
    overflow_seen_next = overflow_seen;
    cur_addr_next      = cur_addr;
    q_pop     = 1'b0;
    cnt_rd    = 1'b0;
    cnt_raddr = q_addr;
    cnt_we    = 1'b0;
    cnt_wdata = cnt_inc;
    cnt_clear = 1'b0;
    text_we   = 1'b0;
    text_rd   = 1'b0;
    res_load  = 1'b0;

    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_PATTERN: begin
              q_pop = 1'b1;
              if (pattern_total >= LIMIT) begin
                overflow_seen_next = 1'b1;
              end else begin
                cnt_rd        = 1'b1;
                cur_addr_next = q_addr;
                state_next    = BK_PAT;
              end
            end
            OP_TEXT: begin
              q_pop = 1'b1;
              if (text_count >= LIMIT) begin
                overflow_seen_next = 1'b1;
              end else begin
                text_we       = 1'b1;
                cnt_rd        = 1'b1;
                cur_addr_next = q_addr;
                state_next    = BK_TXT;
              end
            end
            OP_END: begin
              // hold the item until the result register is free
              if (!result_valid || !result_stall) begin
                q_pop              = 1'b1;
                res_load           = 1'b1;
                cnt_clear          = 1'b1;
                left_edge_next     = '0;
                text_count_next    = '0;
                missing_total_next = '0;
                pattern_total_next = '0;
                best_start_next    = '0;
                best_length_next   = '1;
                best_found_next    = 1'b0;
                overflow_seen_next = 1'b0;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      BK_PAT: begin
        cnt_we             = 1'b1;
        cnt_wdata          = cnt_inc;
        pattern_total_next = pattern_total + LEN_W'(1);
        if (inc_pos) begin
          missing_total_next = missing_total + LEN_W'(1);
        end
        state_next = BK_IDLE;
      end
      BK_TXT: begin
        cnt_we          = 1'b1;
        cnt_wdata       = cnt_dec;
        text_count_next = text_count + LEN_W'(1);
        if (dec_nonneg && (missing_total != '0)) begin
          missing_total_next = missing_total - LEN_W'(1);
        end
        state_next = BK_CHECK;
      end
      BK_CHECK: begin
        if (covered) begin
          // strictly shorter only, so the earliest window wins ties
          if (!best_found || (win_len < best_length)) begin
            best_found_next  = 1'b1;
            best_length_next = win_len;
            best_start_next  = left_edge;
          end
          text_rd    = 1'b1;
          state_next = BK_FETCH;
        end else begin
          state_next = BK_IDLE;
        end
      end
      BK_FETCH: begin
        cnt_rd        = 1'b1;
        cnt_raddr     = ADDR_W'(text_rdata);
        cur_addr_next = ADDR_W'(text_rdata);
        state_next    = BK_GIVE;
      end
      BK_GIVE: begin
        cnt_we         = 1'b1;
        cnt_wdata      = cnt_inc;
        left_edge_next = left_edge + LEN_W'(1);
        if (inc_pos) begin
          missing_total_next = missing_total + LEN_W'(1);
        end
        state_next = BK_CHECK;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      left_edge     <= '0;
      text_count    <= '0;
      missing_total <= '0;
      pattern_total <= '0;
      best_start    <= '0;
      best_length   <= '1;
      best_found    <= 1'b0;
      overflow_seen <= 1'b0;
      cur_addr      <= '0;
      result_valid  <= 1'b0;
    end else begin
      state         <= state_next;
      left_edge     <= left_edge_next;
      text_count    <= text_count_next;
      missing_total <= missing_total_next;
      pattern_total <= pattern_total_next;
      best_start    <= best_start_next;
      best_length   <= best_length_next;
      best_found    <= best_found_next;
      overflow_seen <= overflow_seen_next;
      cur_addr      <= cur_addr_next;
      result_valid  <= res_load || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      found         <= best_found;
      window_start  <= best_found ? START_W'(best_start) : '0;
      window_length <= best_found ? LENGTH_W'(best_length) : '0;
      overflow      <= overflow_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cur_addr] <= cnt_wdata;
    end
    if (cnt_rd) begin
      cnt_rdata <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cnt_clear) begin
      cnt_valid  <= '0;
      cnt_rvalid <= 1'b0;
    end else begin
      if (cnt_we) begin
        cnt_valid[cur_addr] <= 1'b1;
      end
      if (cnt_rd) begin
        cnt_rvalid <= cnt_valid[cnt_raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_we) begin
      text_mem[text_count[TPOS_W-1:0]] <= q_cmd.sym;
    end
    if (text_rd) begin
      text_rdata <= text_mem[left_edge[TPOS_W-1:0]];
    end
  end

endmodule

FILE: rtl/minimum_window_cover_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// minimum_window_cover_unit
// Finds the shortest text window holding every pattern symbol, duplicates
// counted, and reports it when the job ends.
//
//   Channel   Handshake                    Payload
//   item      item_valid / item_stall      kind, symbol
//   result    result_valid / result_stall  found, window_start,
//                                          window_length, overflow
//
// A pattern symbol passes the sequencer states IDLE and PAT, a text symbol
// IDLE, TXT and CHECK, plus FETCH, GIVE and CHECK per left edge step (one
// count table read-modify-write, one text buffer read); an end item only IDLE.
// A four-entry command queue lets items in while the sequencer is busy.
// Reset clears the count table at once through per-entry valid bits, so no
// clearing pass is needed; the same happens after each report.
// An end item waits in the queue while an earlier result is still stalled.
// ---------------------------------------------------------------------------
module minimum_window_cover_unit #(
  parameter int MAX_LEN  = mwc_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = mwc_pkg::ALPHABET_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [mwc_pkg::KIND_W-1:0]    kind,
  input  logic [mwc_pkg::SYM_W-1:0]     symbol,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          found,
  output logic [mwc_pkg::START_W-1:0]   window_start,
  output logic [mwc_pkg::LENGTH_W-1:0]  window_length,
  output logic                          overflow
);
  import mwc_pkg::*;

  logic     push;
  mwc_cmd_t push_cmd;
  logic     q_full;
  logic     q_valid;
  mwc_cmd_t q_cmd;
  logic     q_pop;

  mwc_front #(
    .ALPHABET (ALPHABET)
  ) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .kind       (kind),
    .symbol     (symbol),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  mwc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  mwc_back #(
    .MAX_LEN  (MAX_LEN),
    .ALPHABET (ALPHABET)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .found         (found),
    .window_start  (window_start),
    .window_length (window_length),
    .overflow      (overflow)
  );

endmodule

FILE: verif/tb_minimum_window_cover_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_minimum_window_cover_unit
// Self-checking bench for the minimum window cover unit. An item-level
// software copy of the sliding-window search predicts each report from the
// accepted items. Every report that comes back is compared field by field
// with the oldest prediction. The stimulus covers directed corner jobs,
// a long receiver hold-off and random jobs.
// Both handshakes see random gaps, except while the gaps are switched off.
// ---------------------------------------------------------------------------
module tb_minimum_window_cover_unit;
  import mwc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int MAX_LEN      = MAX_LEN_DEF;
  localparam int ALPHABET     = ALPHABET_DEF;
  localparam int RANDOM_ITEMS = 800;
  localparam int RANDOM_JOBS  = 40;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_NS     = 20000000;

  typedef struct packed {
    logic                found;
    logic [START_W-1:0]  start;
    logic [LENGTH_W-1:0] length;
    logic                overflow;
  } cover_report_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic [KIND_W-1:0]   kind = KIND_PATTERN;
  logic [SYM_W-1:0]    symbol = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic                found;
  logic [START_W-1:0]  window_start;
  logic [LENGTH_W-1:0] window_length;
  logic                overflow;

  // shadow of the search state
  int               demand [ALPHABET];
  logic [SYM_W-1:0] text_copy [MAX_LEN];
  int               left_pos;
  int               text_len;
  int               missing;
  int               pattern_len;
  int               best_pos;
  int               best_len;
  bit               have_best;
  bit               dropped;

  cover_report_t pending_reports [$];
  int            error_count = 0;
  bit            gaps_on = 1'b1;
  int            holds_asked = 0;

  minimum_window_cover_unit u_top (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic clear_cover();
    for (int i = 0; i < ALPHABET; i++) demand[i] = 0;
    left_pos    = 0;
    text_len    = 0;
    missing     = 0;
    pattern_len = 0;
    best_pos    = 0;
    best_len    = 0;
    have_best   = 1'b0;
    dropped     = 1'b0;
  endtask

  task automatic track_cover(input logic [KIND_W-1:0] k, input logic [SYM_W-1:0] s);
    int            idx;
    int            out_idx;
    cover_report_t rep;
    idx = int'(s) % ALPHABET;
    case (k)
      KIND_PATTERN: begin
        if (pattern_len >= MAX_LEN) begin
          dropped = 1'b1;
        end else begin
          pattern_len++;
          demand[idx]++;
          if (demand[idx] > 0) missing++;
        end
      end
      KIND_TEXT: begin
        if (text_len >= MAX_LEN) begin
          dropped = 1'b1;
        end else begin
          text_copy[text_len] = s;
          text_len++;
          demand[idx]--;
          if (demand[idx] >= 0 && missing > 0) missing--;
          // shrink from the left while the window still covers the pattern
          while (pattern_len > 0 && missing == 0 && left_pos < text_len) begin
            if (!have_best || text_len - left_pos < best_len) begin
              have_best = 1'b1;
              best_len  = text_len - left_pos;
              best_pos  = left_pos;
            end
            out_idx = int'(text_copy[left_pos]) % ALPHABET;
            demand[out_idx]++;
            if (demand[out_idx] > 0) missing++;
            left_pos++;
          end
        end
      end
      KIND_END: begin
        rep.found    = have_best;
        rep.start    = have_best ? best_pos[START_W-1:0] : '0;
        rep.length   = have_best ? best_len[LENGTH_W-1:0] : '0;
        rep.overflow = dropped;
        pending_reports.push_back(rep);
        clear_cover();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : check_reports
    cover_report_t want;
    if (rst) begin
      clear_cover();
    end else begin
      if (item_valid && !item_stall) track_cover(kind, symbol);
      if (result_valid && !result_stall) begin
        if (pending_reports.size() == 0) begin
          $error("report arrived with none pending");
          error_count++;
        end else begin
          want = pending_reports.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found);
            error_count++;
          end
          if (window_start !== want.start) begin
            $error("window_start: expected %0d, actual %0d", want.start, window_start);
            error_count++;
          end
          if (window_length !== want.length) begin
            $error("window_length: expected %0d, actual %0d", want.length, window_length);
            error_count++;
          end
          if (overflow !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, overflow);
            error_count++;
          end
        end
      end
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  always @(negedge clk) begin : drive_result_stall
    int r;
    int hold_left;
    int burst_left;
    int holds_done;
    if (rst) begin
      result_stall <= 1'b0;
      hold_left  = 0;
      burst_left = 0;
      holds_done = 0;
    end else if (holds_done != holds_asked) begin
      holds_done = holds_asked;
      hold_left  = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (!gaps_on) begin
      result_stall <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        result_stall <= 1'b0;
        burst_left = $urandom_range(0, 7);
      end else if (r < 95) begin
        result_stall <= 1'b1;
        burst_left = $urandom_range(0, 2);
      end else begin
        result_stall <= 1'b1;
        burst_left = $urandom_range(10, 40);
      end
    end
  end

  function automatic int sender_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] k, input logic [SYM_W-1:0] s);
    int idle;
    idle = sender_gap();
    if (idle > 0) begin
      item_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    item_valid <= 1'b1;
    kind       <= k;
    symbol     <= s;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  task automatic send_run(input logic [KIND_W-1:0] k, input string s);
    for (int i = 0; i < s.len(); i++) send_item(k, SYM_W'(s[i]));
  endtask

  // hold the sender until every report is in, then let the block go quiet
  task automatic settle();
    item_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_empty_job();
    send_item(KIND_END, 7'h7F);
    send_item(KIND_END, 7'h00);
    settle();
  endtask

  task automatic test_alphabet_edges();
    send_item(KIND_PATTERN, 7'h00);
    send_item(KIND_PATTERN, 7'h7F);
    send_item(KIND_TEXT, 7'h7F);
    send_item(KIND_UNUSED, 7'h55);
    send_item(KIND_TEXT, 7'h00);
    send_item(KIND_END, 7'h2A);
    settle();
  endtask

  task automatic test_duplicates_and_ties();
    send_run(KIND_PATTERN, "aa");
    send_run(KIND_TEXT, "abaa");
    send_item(KIND_END, 7'h00);
    settle();
  endtask

  task automatic test_late_pattern();
    send_run(KIND_PATTERN, "a");
    send_run(KIND_TEXT, "a");
    send_run(KIND_PATTERN, "c");
    send_run(KIND_TEXT, "ac");
    send_item(KIND_END, 7'h00);
    settle();
  endtask

  task automatic test_text_without_pattern();
    send_run(KIND_TEXT, "qr");
    send_item(KIND_END, 7'h00);
    settle();
  endtask

  // hold reports back so the command queue fills and the input stalls
  task automatic test_backpressure();
    gaps_on = 1'b0;
    holds_asked++;
    repeat (8) begin
      send_item(KIND_PATTERN, 7'h11);
      send_item(KIND_TEXT, 7'h11);
      send_item(KIND_END, 7'h00);
    end
    settle();
    gaps_on = 1'b1;
  endtask

  function automatic logic [SYM_W-1:0] job_symbol(input int base, input int span);
    if ($urandom_range(0, 9) == 0) return SYM_W'($urandom_range(0, ALPHABET - 1));
    return SYM_W'((base + $urandom_range(0, span - 1)) % ALPHABET);
  endfunction

  task automatic test_random_jobs();
    int sent;
    int jobs;
    int pat_n;
    int txt_n;
    int base;
    int span;
    int r;
    sent = 0;
    jobs = 0;
    while (sent < RANDOM_ITEMS || jobs < RANDOM_JOBS) begin
      // draw each job from a few neighbouring symbols so windows close often
      base  = $urandom_range(0, ALPHABET - 1);
      span  = $urandom_range(1, 6);
      pat_n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      txt_n = $urandom_range(0, 24);
      repeat (pat_n) begin
        send_item(KIND_PATTERN, job_symbol(base, span));
        sent++;
      end
      repeat (txt_n) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_item(KIND_UNUSED, SYM_W'($urandom_range(0, ALPHABET - 1)));
        end else if (r < 8) begin
          send_item(KIND_PATTERN, job_symbol(base, span));
          sent++;
        end else begin
          send_item(KIND_TEXT, job_symbol(base, span));
          sent++;
        end
      end
      send_item(KIND_END, SYM_W'($urandom_range(0, ALPHABET - 1)));
      sent++;
      jobs++;
      if ($urandom_range(0, 9) == 0) gaps_on = !gaps_on;
    end
    gaps_on = 1'b1;
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_job();
    test_alphabet_edges();
    test_duplicates_and_ties();
    test_late_pattern();
    test_text_without_pattern();
    test_backpressure();
    test_random_jobs();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
